FILE: sv/sdf_pkg.sv
// Shared constants for the signed decimal formatter.
package sdf_pkg;

    // Operand and BCD sizes
    localparam int VALUE_W    = 64;
    localparam int NUM_DIGITS = 20;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int ITER_W     = 6;
    localparam int DIG_IDX_W  = 5;
    localparam int WIDTH_W    = 7;

    // Sign mode codes (code 3 acts as SIGN_NEG_ONLY)
    localparam logic [1:0] SIGN_NEG_ONLY = 2'd0;
    localparam logic [1:0] SIGN_PLUS     = 2'd1;
    localparam logic [1:0] SIGN_SPACE    = 2'd2;

    // ASCII codes
    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_SPACE = 8'h20;
    localparam logic [7:0] ASCII_MINUS = 8'h2D;
    localparam logic [7:0] ASCII_PLUS  = 8'h2B;

    // Sequencer states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CONV = 4'b0010,
        ST_PLAN = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

endpackage

FILE: sv/signed_decimal_formatter_core.sv
// Signed 64-bit to padded decimal ASCII formatter, one character per transaction.
//
// Input stream (s_*): one transaction carries a signed value, a sign mode, a
// minimum field width and a fill character. s_tready is high only while the
// block is idle, so one number is formatted at a time.
// Output stream (m_*): one character per transaction, most significant first,
// m_tlast set on the final character of the number.
// Conversion runs a shift-and-add-3 (double dabble) unit over the 64 value
// bits, one bit per cycle, then a planning state sizes the field.
// The characters then leave one per cycle while m_tready is high. A number
// comes out as N characters, N between 1 and max(20, min(min_width, MAX_WIDTH)).
// A stalled receiver holds the current character in the output register and
// freezes the sequence; the block takes the next number once the last
// character is in the output register.
// Reset (rst_n low) returns the sequencer to idle and drops m_tvalid; a number
// in progress is abandoned.
module signed_decimal_formatter_core #(
    parameter int MAX_WIDTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [63:0] value, [65:64] sign_mode, [72:66] min_width, [80:73] fill_char
    input  logic [87:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] out_char
    output logic [7:0]  m_tdata,
    output logic        m_tlast
);

    sdf_pkg::state_t state_reg, state_next;

    logic [sdf_pkg::VALUE_W-1:0]   mag_reg, mag_next;
    logic [sdf_pkg::BCD_W-1:0]     bcd_reg, bcd_next;
    logic [sdf_pkg::ITER_W-1:0]    iter_reg, iter_next;
    logic [7:0]                    sign_char_reg, sign_char_next;
    logic                          has_sign_reg, has_sign_next;
    logic [7:0]                    fill_reg, fill_next;
    logic [sdf_pkg::WIDTH_W-1:0]   width_reg, width_next;
    logic [sdf_pkg::WIDTH_W-1:0]   pre_cnt_reg, pre_cnt_next;
    logic [sdf_pkg::WIDTH_W-1:0]   sign_pos_reg, sign_pos_next;
    logic [sdf_pkg::WIDTH_W-1:0]   k_reg, k_next;
    logic [sdf_pkg::DIG_IDX_W-1:0] dig_idx_reg, dig_idx_next;
    logic [7:0]                    out_char_reg, out_char_next;
    logic                          out_last_reg, out_last_next;
    logic                          out_valid_reg, out_valid_next;

    // Input fields
    logic [sdf_pkg::VALUE_W-1:0] in_value;
    logic [1:0]                  in_sign_mode;
    logic [6:0]                  in_min_width;
    logic [7:0]                  in_fill_char;

    assign in_value     = s_tdata[63:0];
    assign in_sign_mode = s_tdata[65:64];
    assign in_min_width = s_tdata[72:66];
    assign in_fill_char = s_tdata[80:73];

    // Ports
    assign s_tready = (state_reg == sdf_pkg::ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tlast  = out_last_reg;

    // Shift-and-add-3 adjust on every BCD digit
    logic [sdf_pkg::BCD_W-1:0] bcd_adj;
    always_comb
    begin
        for (int i = 0; i < sdf_pkg::NUM_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            else
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
    end

    // Highest nonzero digit
    logic [sdf_pkg::DIG_IDX_W-1:0] top_digit;
    always_comb
    begin
        top_digit = '0;
        for (int i = 0; i < sdf_pkg::NUM_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] != 4'd0)
                top_digit = sdf_pkg::DIG_IDX_W'(i);
        end
    end

    // Field sizing
    logic [sdf_pkg::WIDTH_W-1:0] char_cnt;
    logic [sdf_pkg::WIDTH_W-1:0] pad_cnt;
    logic                        zero_fill;
    assign char_cnt  = sdf_pkg::WIDTH_W'(top_digit) + 7'd1 + sdf_pkg::WIDTH_W'(has_sign_reg);
    assign pad_cnt   = (width_reg > char_cnt) ? (width_reg - char_cnt) : '0;
    assign zero_fill = (fill_reg == sdf_pkg::ASCII_ZERO);

    // Width cap at MAX_WIDTH
    logic [sdf_pkg::WIDTH_W-1:0] width_cap;
    assign width_cap = ({1'b0, in_min_width} > 8'(MAX_WIDTH)) ? sdf_pkg::WIDTH_W'(MAX_WIDTH)
                                                                : in_min_width;

    // Current digit
    logic [3:0] cur_digit;
    assign cur_digit = bcd_reg[{dig_idx_reg, 2'b00} +: 4];

    logic out_load;
    assign out_load = !out_valid_reg || m_tready;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        bcd_next       = bcd_reg;
        iter_next      = iter_reg;
        sign_char_next = sign_char_reg;
        has_sign_next  = has_sign_reg;
        fill_next      = fill_reg;
        width_next     = width_reg;
        pre_cnt_next   = pre_cnt_reg;
        sign_pos_next  = sign_pos_reg;
        k_next         = k_reg;
        dig_idx_next   = dig_idx_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg;

        if (m_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            sdf_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    mag_next   = in_value[63] ? (64'd0 - in_value) : in_value;
                    bcd_next   = '0;
                    iter_next  = '0;
                    fill_next  = in_fill_char;
                    width_next = width_cap;
                    if (in_value[63])
                    begin
                        sign_char_next = sdf_pkg::ASCII_MINUS;
                        has_sign_next  = 1'b1;
                    end
                    else if (in_sign_mode == sdf_pkg::SIGN_PLUS)
                    begin
                        sign_char_next = sdf_pkg::ASCII_PLUS;
                        has_sign_next  = 1'b1;
                    end
                    else if (in_sign_mode == sdf_pkg::SIGN_SPACE)
                    begin
                        sign_char_next = sdf_pkg::ASCII_SPACE;
                        has_sign_next  = 1'b1;
                    end
                    else
                    begin
                        sign_char_next = sdf_pkg::ASCII_SPACE;
                        has_sign_next  = 1'b0;
                    end
                    state_next = sdf_pkg::ST_CONV;
                end
            end

            sdf_pkg::ST_CONV:
            begin
                bcd_next  = {bcd_adj[sdf_pkg::BCD_W-2:0], mag_reg[sdf_pkg::VALUE_W-1]};
                mag_next  = {mag_reg[sdf_pkg::VALUE_W-2:0], 1'b0};
                iter_next = iter_reg + sdf_pkg::ITER_W'(1);
                if (iter_reg == '1)
                    state_next = sdf_pkg::ST_PLAN;
            end

            sdf_pkg::ST_PLAN:
            begin
                pre_cnt_next  = pad_cnt + sdf_pkg::WIDTH_W'(has_sign_reg);
                sign_pos_next = zero_fill ? '0 : pad_cnt;
                dig_idx_next  = top_digit;
                k_next        = '0;
                state_next    = sdf_pkg::ST_EMIT;
            end

            sdf_pkg::ST_EMIT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    if (k_reg < pre_cnt_reg)
                    begin
                        // Padding or sign
                        out_last_next = 1'b0;
                        if (has_sign_reg && (k_reg == sign_pos_reg))
                            out_char_next = sign_char_reg;
                        else
                            out_char_next = fill_reg;
                        k_next = k_reg + sdf_pkg::WIDTH_W'(1);
                    end
                    else
                    begin
                        // Digits, most significant first
                        out_char_next = sdf_pkg::ASCII_ZERO + {4'd0, cur_digit};
                        out_last_next = (dig_idx_reg == '0);
                        dig_idx_next  = dig_idx_reg - sdf_pkg::DIG_IDX_W'(1);
                        if (dig_idx_reg == '0)
                            state_next = sdf_pkg::ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = sdf_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sdf_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        mag_reg       <= mag_next;
        bcd_reg       <= bcd_next;
        iter_reg      <= iter_next;
        sign_char_reg <= sign_char_next;
        has_sign_reg  <= has_sign_next;
        fill_reg      <= fill_next;
        width_reg     <= width_next;
        pre_cnt_reg   <= pre_cnt_next;
        sign_pos_reg  <= sign_pos_next;
        k_reg         <= k_next;
        dig_idx_reg   <= dig_idx_next;
        out_char_reg  <= out_char_next;
        out_last_reg  <= out_last_next;
    end

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the signed decimal formatter core.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         FIELD_MAX   = 64;
    localparam int         NUM_RANDOM  = 460;
    localparam int         IDLE_PCT    = 30;
    localparam int         QUIET_FROM  = 180;      // no idling on either side for
    localparam int         QUIET_TO    = 280;      // numbers in this range
    localparam int         TAIL_CYCLES = 200;
    localparam int         CYCLE_LIMIT = 1_000_000;
    localparam int         MAX_REPORTS = 25;
    localparam logic [1:0] SIGN_UNUSED = 2'd3;     // behaves like negative-only
    localparam logic [63:0] VAL_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] VAL_MIN    = 64'h8000_0000_0000_0000;

    // One input transaction, laid out as on s_tdata (value in the low bits)
    typedef struct packed {
        logic [6:0]  spare;
        logic [7:0]  fill_char;
        logic [6:0]  min_width;
        logic [1:0]  sign_mode;
        logic [63:0] value;
    } fmt_req_t;

    // One output character with its end-of-number mark
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } fmt_char_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [87:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    fmt_req_t    number_q[$];        // numbers waiting to be sent
    fmt_char_t   char_expect_q[$];   // characters still owed by the block
    fmt_char_t   exp_c;
    int          n_items;
    int          n_presented = 0;
    int          n_accepted  = 0;
    int          n_chars     = 0;
    int          n_negative  = 0;
    int          n_zero_fill = 0;
    int          longest     = 0;
    int          errors      = 0;
    int          cycles      = 0;

    signed_decimal_formatter_core #(
        .MAX_WIDTH (FIELD_MAX)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #1 clk = ~clk;

    // Expected text of one number, appended to the character queue
    function automatic void format_decimal(input fmt_req_t req);
        logic [63:0] mag;
        logic [7:0]  digit_chars [20];
        logic [7:0]  sign_char;
        logic [7:0]  text [$];
        bit          has_sign;
        int          nd;
        int          width;
        int          pad;
        mag = req.value[63] ? (64'd0 - req.value) : req.value;
        width = (int'(req.min_width) > FIELD_MAX) ? FIELD_MAX : int'(req.min_width);
        has_sign = 1'b1;
        sign_char = sdf_pkg::ASCII_SPACE;
        if (req.value[63])
            sign_char = sdf_pkg::ASCII_MINUS;
        else if (req.sign_mode == sdf_pkg::SIGN_PLUS)
            sign_char = sdf_pkg::ASCII_PLUS;
        else if (req.sign_mode == sdf_pkg::SIGN_SPACE)
            sign_char = sdf_pkg::ASCII_SPACE;
        else
            has_sign = 1'b0;
        // digits come out least significant first
        nd = 0;
        do
        begin
            digit_chars[nd] = sdf_pkg::ASCII_ZERO + 8'(mag % 64'd10);
            nd++;
            mag = mag / 64'd10;
        end
        while (mag != 64'd0 && nd < sdf_pkg::NUM_DIGITS);
        pad = width - nd - (has_sign ? 1 : 0);
        if (pad < 0)
            pad = 0;
        // zero fill puts the sign ahead of the padding, any other fill after it
        if (req.fill_char == sdf_pkg::ASCII_ZERO && has_sign)
            text.push_back(sign_char);
        repeat (pad) text.push_back(req.fill_char);
        if (req.fill_char != sdf_pkg::ASCII_ZERO && has_sign)
            text.push_back(sign_char);
        for (int i = nd - 1; i >= 0; i--)
            text.push_back(digit_chars[i]);
        foreach (text[k])
            char_expect_q.push_back('{ch: text[k], last: (k == text.size() - 1)});
        if (req.value[63])
            n_negative++;
        if (req.fill_char == sdf_pkg::ASCII_ZERO)
            n_zero_fill++;
        if (text.size() > longest)
            longest = text.size();
    endfunction

    function automatic fmt_req_t make_req(input logic [63:0] value, input logic [1:0] mode,
                                          input logic [6:0] width, input logic [7:0] fill);
        fmt_req_t req;
        req = '0;
        req.value     = value;
        req.sign_mode = mode;
        req.min_width = width;
        req.fill_char = fill;
        return req;
    endfunction

    // Random value: full range, small numbers, powers of ten, extremes, 32-bit and shifted values
    function automatic logic [63:0] pick_value();
        logic [63:0] p;
        logic [31:0] r;
        int          small_v;
        p = 64'd1;
        r = $urandom;
        small_v = int'($urandom_range(0, 2000)) - 1000;
        case ($urandom_range(0, 5))
            0: return {$urandom, $urandom};
            1: return 64'(small_v);
            2:
            begin
                repeat ($urandom_range(0, 19)) p = p * 64'd10;
                if ($urandom_range(0, 1) != 0)
                    p = 64'd0 - p;
                return p + 64'($urandom_range(0, 2)) - 64'd1;
            end
            3:
            begin
                if ($urandom_range(0, 1) != 0)
                    return VAL_MAX - 64'($urandom_range(0, 3));
                return VAL_MIN + 64'($urandom_range(0, 3));
            end
            4: return {{32{r[31]}}, r};
            default:
            begin
                p = {$urandom, $urandom} >> $urandom_range(0, 63);
                return ($urandom_range(0, 1) != 0) ? (64'd0 - p) : p;
            end
        endcase
    endfunction

    function automatic fmt_req_t random_req();
        logic [6:0] width;
        logic [7:0] fill;
        width = ($urandom_range(0, 4) != 0) ? 7'($urandom_range(0, 24))
                                            : 7'($urandom_range(0, 127));
        case ($urandom_range(0, 9))
            0, 1, 2, 3: fill = sdf_pkg::ASCII_ZERO;
            4, 5, 6:    fill = sdf_pkg::ASCII_SPACE;
            default:    fill = 8'($urandom_range(0, 255));
        endcase
        return make_req(pick_value(), 2'($urandom_range(0, 3)), width, fill);
    endfunction

    // Idle decision for either side, off during the quiet stretch
    function automatic bit idle_roll();
        if (n_accepted >= QUIET_FROM && n_accepted < QUIET_TO)
            return 1'b0;
        return $urandom_range(0, 99) < IDLE_PCT;
    endfunction

    // Input driver and receiver backpressure, changed on the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_tvalid || n_accepted == n_presented)
            begin
                if (number_q.size() != 0 && !idle_roll())
                begin
                    s_tdata  <= number_q.pop_front();
                    s_tvalid <= 1'b1;
                    n_presented++;
                end
                else
                    s_tvalid <= 1'b0;
            end
            m_tready <= !idle_roll();
        end
    end

    // Monitor: check output characters first, then predict accepted numbers
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                n_chars++;
                if (char_expect_q.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: unexpected character: expected none, actual %h last %b",
                                 $time, m_tdata, m_tlast);
                end
                else
                begin
                    exp_c = char_expect_q.pop_front();
                    if (m_tdata !== exp_c.ch)
                    begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display("%0t: out_char mismatch: expected %h actual %h",
                                     $time, exp_c.ch, m_tdata);
                    end
                    if (m_tlast !== exp_c.last)
                    begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display("%0t: last mismatch: expected %b actual %b",
                                     $time, exp_c.last, m_tlast);
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                format_decimal(fmt_req_t'(s_tdata));
                n_accepted++;
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("signed_decimal_formatter_core verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;

        // directed: extremes, every sign mode, padding order, width cap, odd fills
        number_q.push_back(make_req(64'd0, sdf_pkg::SIGN_NEG_ONLY, 7'd0, sdf_pkg::ASCII_SPACE));
        number_q.push_back(make_req(64'd0, sdf_pkg::SIGN_PLUS, 7'd0, sdf_pkg::ASCII_SPACE));
        number_q.push_back(make_req(64'd0, sdf_pkg::SIGN_SPACE, 7'd3, "*"));
        number_q.push_back(make_req(VAL_MAX, sdf_pkg::SIGN_NEG_ONLY, 7'd0, sdf_pkg::ASCII_SPACE));
        number_q.push_back(make_req(VAL_MIN, sdf_pkg::SIGN_NEG_ONLY, 7'd0, sdf_pkg::ASCII_SPACE));
        number_q.push_back(make_req(VAL_MIN, sdf_pkg::SIGN_PLUS, 7'd64, sdf_pkg::ASCII_ZERO));
        number_q.push_back(make_req(-64'sd1, sdf_pkg::SIGN_SPACE, 7'd5, sdf_pkg::ASCII_SPACE));
        number_q.push_back(make_req(64'd42, SIGN_UNUSED, 7'd4, sdf_pkg::ASCII_ZERO));
        number_q.push_back(make_req(64'd42, sdf_pkg::SIGN_PLUS, 7'd6, sdf_pkg::ASCII_ZERO));
        number_q.push_back(make_req(64'd42, sdf_pkg::SIGN_NEG_ONLY, 7'd6, sdf_pkg::ASCII_ZERO));
        number_q.push_back(make_req(64'd123, sdf_pkg::SIGN_SPACE, 7'd127, "_"));
        number_q.push_back(make_req(64'd123, sdf_pkg::SIGN_PLUS, 7'd65, sdf_pkg::ASCII_ZERO));
        number_q.push_back(make_req(-64'sd7, sdf_pkg::SIGN_NEG_ONLY, 7'd64, 8'h00));
        number_q.push_back(make_req(64'd9, sdf_pkg::SIGN_PLUS, 7'd10, 8'hFF));
        number_q.push_back(make_req(VAL_MAX, sdf_pkg::SIGN_PLUS, 7'd20, sdf_pkg::ASCII_SPACE));
        number_q.push_back(make_req(VAL_MAX, sdf_pkg::SIGN_PLUS, 7'd21, sdf_pkg::ASCII_ZERO));
        number_q.push_back(make_req(VAL_MIN, sdf_pkg::SIGN_NEG_ONLY, 7'd21,
                                    sdf_pkg::ASCII_SPACE));
        number_q.push_back(make_req(64'd1_000_000_000_000_000_000, sdf_pkg::SIGN_SPACE, 7'd0,
                                    sdf_pkg::ASCII_SPACE));
        number_q.push_back(make_req(64'd999_999_999_999_999_999, SIGN_UNUSED, 7'd19, "#"));
        number_q.push_back(make_req(-64'sd10, sdf_pkg::SIGN_PLUS, 7'd1, sdf_pkg::ASCII_ZERO));
        number_q.push_back(make_req(64'd5, sdf_pkg::SIGN_NEG_ONLY, 7'd1, sdf_pkg::ASCII_SPACE));
        number_q.push_back(make_req(-64'sd5, sdf_pkg::SIGN_SPACE, 7'd2, sdf_pkg::ASCII_ZERO));
        number_q.push_back(make_req(64'd7, SIGN_UNUSED, 7'd127, 8'h7F));

        // random numbers
        repeat (NUM_RANDOM) number_q.push_back(random_req());
        n_items = number_q.size();

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // drain: all numbers taken, all characters seen, then a quiet tail
        while (n_accepted < n_items) @(posedge clk);
        while (char_expect_q.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Formatted %0d numbers (%0d negative, %0d zero-filled) into %0d characters;",
                 n_accepted, n_negative, n_zero_fill, n_chars);
        $display("longest field %0d characters, %0d check errors.", longest, errors);
        if (errors == 0)
            $display("signed_decimal_formatter_core verification clean");
        else
            $display("signed_decimal_formatter_core verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
sv/sdf_pkg.sv
sv/signed_decimal_formatter_core.sv
tb/tb_top.sv
